### hdl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

  localparam int unsigned Rounds = 64;

  typedef logic [31:0] word_t;

  // round constants
  localparam word_t ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  function automatic word_t ror(input word_t v, input int unsigned s);
    ror = (v >> s) | (v << (32 - s));
  endfunction

endpackage

### hdl/sha256_message_hasher.sv
`timescale 1ns / 1ps
// channel | ports                                      | direction
// in      | in_valid in_ready in_data_byte             | into block
//         | in_byte_valid in_last_byte                 |
// out     | out_valid out_ready out_digest_word        | out of block
//         | out_word_index out_last_word               |
// the 64th byte of a block holds in_ready low for 64 rounds on the shared
// round unit, then one chain add
// a closing item pads one byte per cycle up to the end of the block, then
// 64 rounds and a chain add; a marker at byte 56 or later adds a second
// block of padding, 64 rounds and one add
// the digest then goes out as eight words, one per out_ready cycle
// rst_n is synchronous; after reset the chain holds the initial hash values
// in_ready is low while padding, compressing or delivering the digest
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha_pkg::state_t state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] len_r, len_nxt;
  logic        fin_r, fin_nxt;     // closing item in progress
  logic        mark_r, mark_nxt;   // pad marker already written
  logic        two_r, two_nxt;     // marker left no room for the length
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  sha_pkg::word_t h_r [8];
  sha_pkg::word_t h_nxt [8];
  sha_pkg::word_t v_r [8];
  sha_pkg::word_t v_nxt [8];
  sha_pkg::word_t w_r [16];
  sha_pkg::word_t w_nxt [16];
  logic [7:0]  bdata;

  logic        acc;
  sha_pkg::word_t wt, s0, s1, t1, t2;

  assign in_ready = (state_r == sha_pkg::ST_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = (state_r == sha_pkg::ST_OUT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index = oidx_r;
  assign out_last_word = (oidx_r == 3'd7);

  // shared round unit
  always_comb begin
    s0 = sha_pkg::ror(w_r[1], 7) ^ sha_pkg::ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = sha_pkg::ror(w_r[14], 17) ^ sha_pkg::ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wt = (rnd_r < 6'd16) ? w_r[0] : (w_r[0] + s0 + w_r[9] + s1);
    t1 = v_r[7] + (sha_pkg::ror(v_r[4], 6) ^ sha_pkg::ror(v_r[4], 11) ^
         sha_pkg::ror(v_r[4], 25)) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + wt + sha_pkg::ROUND_K[rnd_r];
    t2 = (sha_pkg::ror(v_r[0], 2) ^ sha_pkg::ror(v_r[0], 13) ^
          sha_pkg::ror(v_r[0], 22)) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // sequencer; message bytes go straight into the schedule window
  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    len_nxt = len_r;
    fin_nxt = fin_r;
    mark_nxt = mark_r;
    two_nxt = two_r;
    rnd_nxt = rnd_r;
    oidx_nxt = oidx_r;
    h_nxt = h_r;
    v_nxt = v_r;
    w_nxt = w_r;
    bdata = 8'h00;
    case (state_r)
      sha_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_byte_valid) begin
            w_nxt[pos_r[5:2]][{~pos_r[1:0], 3'd0} +: 8] = in_data_byte;
            pos_nxt = pos_r + 6'd1;
            len_nxt = len_r + 64'd8;
          end
          fin_nxt = in_last_byte;
          if (in_byte_valid && pos_r == 6'd63) begin
            state_nxt = sha_pkg::ST_ROUND;
            rnd_nxt = '0;
            v_nxt = h_r;
          end else if (in_last_byte) begin
            state_nxt = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        // marker first, then zeros, length bytes at the tail of the last block
        if (!mark_r) begin
          bdata = sha_pkg::PAD_BYTE;
          mark_nxt = 1'b1;
          two_nxt = (pos_r >= sha_pkg::LEN_POS);
        end else if (pos_r >= sha_pkg::LEN_POS && !two_r) begin
          bdata = len_r[{3'd7 - pos_r[2:0], 3'd0} +: 8];
        end
        w_nxt[pos_r[5:2]][{~pos_r[1:0], 3'd0} +: 8] = bdata;
        pos_nxt = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          state_nxt = sha_pkg::ST_ROUND;
          rnd_nxt = '0;
          v_nxt = h_r;
        end
      end
      sha_pkg::ST_ROUND: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[15] = wt;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = sha_pkg::ST_ADD;
        end
      end
      sha_pkg::ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        if (!fin_r) begin
          state_nxt = sha_pkg::ST_IDLE;
        end else if (mark_r && !two_r) begin
          state_nxt = sha_pkg::ST_OUT;
          oidx_nxt = '0;
        end else begin
          // padding block with the length still to come
          state_nxt = sha_pkg::ST_PAD;
          two_nxt = 1'b0;
        end
      end
      sha_pkg::ST_OUT: begin
        if (out_ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            state_nxt = sha_pkg::ST_IDLE;
            h_nxt = sha_pkg::INIT_H;
            len_nxt = '0;
            pos_nxt = '0;
            fin_nxt = 1'b0;
            mark_nxt = 1'b0;
            two_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_IDLE;
      pos_r <= '0;
      len_r <= '0;
      fin_r <= 1'b0;
      mark_r <= 1'b0;
      two_r <= 1'b0;
      rnd_r <= '0;
      oidx_r <= '0;
      h_r <= sha_pkg::INIT_H;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      fin_r <= fin_nxt;
      mark_r <= mark_nxt;
      two_r <= two_nxt;
      rnd_r <= rnd_nxt;
      oidx_r <= oidx_nxt;
      h_r <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

  // no item taken while the digest is offered
  a_no_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during digest");

  // a stalled word keeps its index
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_index))
    else $error("digest index moved while stalled");

  // round counter only advances in the round state
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != sha_pkg::ST_ROUND && $past(state_r) != sha_pkg::ST_ROUND
    |-> $stable(rnd_r) || state_r == sha_pkg::ST_ROUND)
    else $error("round counter moved outside rounds");

endmodule

### tb/sv/sha256_message_hasher_tb.sv
`timescale 1ns / 1ps
module sha256_message_hasher_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_byte_valid = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];
  int unsigned  mismatches = 0;
  longint unsigned cycle_count = 0;
  bit           hold_off = 1'b0;
  bit           no_stall = 1'b0;

  // own copy of the hashing state
  logic [7:0]  msg_block [64];
  int unsigned msg_fill;
  logic [63:0] msg_bits;
  sha_pkg::word_t chain_h [8];

  sha256_message_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_byte_valid(in_byte_valid),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("sha256_message_hasher test failed");
      $finish;
    end
  end

  function automatic sha_pkg::word_t rotr(sha_pkg::word_t v, int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic void hash_restart();
    msg_fill = 0;
    msg_bits = '0;
    for (int i = 0; i < 8; i++) chain_h[i] = sha_pkg::INIT_H[i];
  endfunction

  function automatic void compress_msg_block();
    sha_pkg::word_t w [16];
    sha_pkg::word_t v [8];
    sha_pkg::word_t wt, s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        s0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
        s1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
        wt = w[t&15] + s0 + w[(t-7)&15] + s1;
        w[t&15] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + wt + sha_pkg::ROUND_K[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += v[i];
  endfunction

  // predict the digest words caused by one item
  function automatic void hash_item(logic [7:0] data, logic bv, logic last);
    digest_word_t dw;
    if (bv) begin
      msg_block[msg_fill] = data;
      msg_fill = (msg_fill + 1) % 64;
      msg_bits += 64'd8;
      if (msg_fill == 0) compress_msg_block();
    end
    if (!last) return;
    msg_block[msg_fill] = sha_pkg::PAD_BYTE;
    msg_fill = msg_fill + 1;
    if (msg_fill > 56) begin
      for (int i = msg_fill; i < 64; i++) msg_block[i] = 8'h00;
      compress_msg_block();
      msg_fill = 0;
    end
    for (int i = msg_fill; i < 56; i++) msg_block[i] = 8'h00;
    for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
    compress_msg_block();
    for (int i = 0; i < 8; i++) begin
      dw.word = chain_h[i];
      dw.index = 3'(i);
      dw.last = (i == 7);
      digest_q = {digest_q, dw};
    end
    hash_restart();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
  endtask

  // send one item, bursts with random gaps
  task automatic send_item(logic [7:0] data, logic bv, logic last);
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_byte_valid <= bv;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    hash_item(data, bv, last);
  endtask

  // drop valid after the last accepted item
  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_message(int unsigned len, bit end_only, int unsigned fill_mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (fill_mode)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(b, 1'b1, !end_only && (i == len - 1));
    end
    if (end_only || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (no_stall) out_ready <= 1'b1;
    else out_ready <= (cycle_count % 11 < 7) ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  // check each digest word
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", out_digest_word, 32'h0);
      end else begin
        exp_w = digest_q.pop_front();
        if (out_digest_word !== exp_w.word)
          report_mismatch("digest_word", out_digest_word, exp_w.word);
        if (out_word_index !== exp_w.index)
          report_mismatch("word_index", 32'(out_word_index), 32'(exp_w.index));
        if (out_last_word !== exp_w.last)
          report_mismatch("last_word", 32'(out_last_word), 32'(exp_w.last));
      end
    end
  end

  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b0);          // empty item
    send_item(8'h00, 1'b0, 1'b1);          // empty message
    send_message(3, 1'b0, 2);
    send_message(1, 1'b0, 1);
    send_message(1, 1'b1, 0);              // byte then end-only item
    wait_drained();
    send_message(55, 1'b0, 1);             // padding fits one block
    send_message(56, 1'b0, 0);             // padding needs a second block
    send_message(64, 1'b0, 2);             // full block exactly
    wait_drained();
  endtask

  task automatic test_long_hold_off();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_message(2, 1'b0, 2);
        send_message(2, 1'b0, 2);
        send_message(4, 1'b1, 2);
        stop_sending();
      end
    join
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 260) begin
      no_stall = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      send_message(len, $urandom_range(0, 3) == 0, ($urandom_range(0, 9) == 0) ? 1 : 2);
      sent += len + 1;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    no_stall = 1'b0;
  endtask

  initial begin
    hash_restart();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_hold_off();
    test_random();
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("sha256_message_hasher test passed");
    end else begin
      $display("sha256_message_hasher test failed");
    end
    $finish;
  end

endmodule
